/* hdl/svd_pkg.sv */
// shared widths, constants and types for the 3x2 closed-form svd block
// no dependencies; used by every module under hdl except svd_isqrt and svd_div
package svd_pkg;

  // fixed point format of matrix entries and results
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 20;
  localparam int EPS_W     = 16;

  // magnitudes of p = m00 - m11 and q = -2*m01
  localparam int M_W   = 41;
  localparam int NRM_W = 31;
  localparam int SH_W  = $clog2(M_W - NRM_W + 1);

  // radius square root and x = |p| / r
  localparam int R_RAD_W = 64;
  localparam int R_W     = R_RAD_W / 2;
  localparam int X_NUM_W = NRM_W + FRAC_BITS;
  localparam int X_W     = FRAC_BITS + 1;

  // cosine and sine square roots
  localparam int CS_RAD_W = 2 * X_W;
  localparam int CS_W     = CS_RAD_W / 2;
  localparam int CS_SW    = CS_W + 1;

  // rotated columns, singular values and left factor
  localparam int WM_W      = 21;
  localparam int SIG_RAD_W = 44;
  localparam int SIG_W     = SIG_RAD_W / 2;
  localparam int U_NUM_W   = WM_W + FRAC_BITS + 1;
  localparam int U_W       = 18;
  localparam int SIGMA_W   = 21;
  localparam int COS_W     = 17;
  localparam int SIN_W     = 17;

  // request queue between front and back
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  // configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic REG_EPS_THRESHOLD = 1'b0;
  localparam logic [EPS_W-1:0] EPS_RESET = 16'd1;

  // one in fixed point
  localparam logic [X_W:0] ONE = (X_W + 1)'(1) << FRAC_BITS;

  typedef logic [5:0][IN_W-1:0] svd_mat_t;

  // classified request handed from front to back
  typedef struct packed {
    svd_mat_t         a;
    logic [M_W-1:0]   pm;
    logic [M_W-1:0]   qm;
    logic             sflip;
    logic             ident;
  } svd_item_t;

endpackage

/* hdl/svd_isqrt.sv */
// pipelined integer square root, one result bit per stage, with side tag
// depends on nothing; instantiated by svd_back
module svd_isqrt #(
  parameter int RW = 64,
  parameter int TW = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [RW-1:0]   rad_i,
  input  logic [TW-1:0]   tag_i,
  output logic            vld_o,
  output logic [RW/2-1:0] root_o,
  output logic [TW-1:0]   tag_o
);

  localparam int N = RW / 2;

  logic [RW-1:0] rem_r  [N];
  logic [N-1:0]  root_r [N];
  logic [TW-1:0] tag_r  [N];
  logic [N-1:0]  vld_r;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam int B = N - 1 - i;
    logic [RW-1:0] rem_in;
    logic [N-1:0]  root_in;
    logic [TW-1:0] tag_in;
    logic          vld_in;
    logic [RW-1:0] trial;
    logic [RW-1:0] rem_nxt;
    logic [N-1:0]  root_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign tag_in  = tag_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign tag_in  = tag_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    // try setting root bit B
    always_comb begin
      trial    = (RW'(root_in) << (B + 1)) | (RW'(1) << (2 * B));
      rem_nxt  = rem_in;
      root_nxt = root_in;
      if (rem_in >= trial) begin
        rem_nxt  = rem_in - trial;
        root_nxt = root_in | (N'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        tag_r[i]  <= tag_in;
      end
    end
  end

  assign vld_o  = vld_r[N-1];
  assign root_o = root_r[N-1];
  assign tag_o  = tag_r[N-1];

endmodule

/* hdl/svd_div.sv */
// pipelined restoring divider, one quotient bit per stage, with side tag
// depends on nothing; instantiated by svd_back
module svd_div #(
  parameter int NW = 47,
  parameter int DW = 32,
  parameter int QW = 17,
  parameter int TW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          vld_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  input  logic [TW-1:0] tag_i,
  output logic          vld_o,
  output logic [QW-1:0] quo_o,
  output logic [TW-1:0] tag_o
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;

  logic [XW-1:0] rem_r [QW];
  logic [DW-1:0] den_r [QW];
  logic [QW-1:0] quo_r [QW];
  logic [TW-1:0] tag_r [QW];
  logic [QW-1:0] vld_r;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int B = QW - 1 - i;
    logic [XW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [TW-1:0] tag_in;
    logic          vld_in;
    logic [XW-1:0] dsh;
    logic [XW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign rem_in = XW'(num_i);
      assign den_in = den_i;
      assign quo_in = '0;
      assign tag_in = tag_i;
      assign vld_in = vld_i;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
      assign tag_in = tag_r[i-1];
      assign vld_in = vld_r[i-1];
    end

    // subtract shifted divisor when it fits
    always_comb begin
      dsh     = XW'(den_in) << B;
      rem_nxt = rem_in;
      quo_nxt = quo_in;
      if (rem_in >= dsh) begin
        rem_nxt = rem_in - dsh;
        quo_nxt = quo_in | (QW'(1) << B);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (en) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= rem_nxt;
        den_r[i] <= den_in;
        quo_r[i] <= quo_nxt;
        tag_r[i] <= tag_in;
      end
    end
  end

  assign vld_o = vld_r[QW-1];
  assign quo_o = quo_r[QW-1];
  assign tag_o = tag_r[QW-1];

endmodule

/* hdl/svd_front.sv */
// front end: accepts a matrix, forms A-transpose-A and classifies the request
// depends on svd_pkg; feeds svd_queue
module svd_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [svd_pkg::IN_W-1:0]   in_a00,
  input  logic signed [svd_pkg::IN_W-1:0]   in_a01,
  input  logic signed [svd_pkg::IN_W-1:0]   in_a10,
  input  logic signed [svd_pkg::IN_W-1:0]   in_a11,
  input  logic signed [svd_pkg::IN_W-1:0]   in_a20,
  input  logic signed [svd_pkg::IN_W-1:0]   in_a21,
  input  logic [svd_pkg::EPS_W-1:0]         eps_i,
  input  logic                              full_i,
  output logic                              push_o,
  output svd_pkg::svd_item_t                item_o
);

  localparam int PW = 2 * svd_pkg::IN_W;
  localparam int SW = PW + 2;
  localparam int IN_W_L = svd_pkg::IN_W;

  logic                 va_r;
  logic                 vb_r;
  logic                 en_a;
  logic                 en_b;
  logic signed [PW-1:0] p00_r [3];
  logic signed [PW-1:0] p01_r [3];
  logic signed [PW-1:0] p11_r [3];
  svd_pkg::svd_mat_t    a_r;
  svd_pkg::svd_item_t   item_r;
  svd_pkg::svd_item_t   item_nxt;
  logic signed [IN_W_L-1:0] ain [6];

  // stage enables
  assign en_b     = !vb_r || !full_i;
  assign en_a     = !va_r || en_b;
  assign in_ready = en_a;
  assign push_o   = vb_r && !full_i;
  assign item_o   = item_r;

  assign ain[0] = in_a00;
  assign ain[1] = in_a01;
  assign ain[2] = in_a10;
  assign ain[3] = in_a11;
  assign ain[4] = in_a20;
  assign ain[5] = in_a21;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) va_r <= in_valid;
      if (en_b) vb_r <= va_r;
    end
  end

  // stage a: entry products
  always_ff @(posedge clk) begin
    if (en_a) begin
      for (int i = 0; i < 3; i++) begin
        p00_r[i] <= ain[2*i] * ain[2*i];
        p01_r[i] <= ain[2*i] * ain[2*i+1];
        p11_r[i] <= ain[2*i+1] * ain[2*i+1];
      end
      for (int i = 0; i < 6; i++) a_r[i] <= ain[i];
    end
  end

  // stage b: sums, rotation operands and the identity test
  always_comb begin
    logic signed [SW-1:0] m00;
    logic signed [SW-1:0] m01;
    logic signed [SW-1:0] m11;
    logic signed [SW-1:0] p;
    logic signed [SW-1:0] q;
    logic [SW-1:0]        m01m;
    logic [SW-1:0]        eps_sh;
    m00      = SW'(p00_r[0]) + SW'(p00_r[1]) + SW'(p00_r[2]);
    m01      = SW'(p01_r[0]) + SW'(p01_r[1]) + SW'(p01_r[2]);
    m11      = SW'(p11_r[0]) + SW'(p11_r[1]) + SW'(p11_r[2]);
    p        = m00 - m11;
    q        = -(m01 <<< 1);
    m01m     = m01[SW-1] ? SW'(-m01) : SW'(m01);
    eps_sh   = SW'(eps_i) << svd_pkg::FRAC_BITS;
    item_nxt.a     = a_r;
    item_nxt.pm    = p[SW-1] ? svd_pkg::M_W'(-p) : svd_pkg::M_W'(p);
    item_nxt.qm    = q[SW-1] ? svd_pkg::M_W'(-q) : svd_pkg::M_W'(q);
    item_nxt.sflip = p[SW-1] != q[SW-1];
    item_nxt.ident = m01m < eps_sh;
  end

  always_ff @(posedge clk) begin
    if (en_b) item_r <= item_nxt;
  end

endmodule

/* hdl/svd_queue.sv */
// short request queue that decouples the front end from the back end
// depends on svd_pkg; sits between svd_front and svd_back
module svd_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  svd_pkg::svd_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output svd_pkg::svd_item_t item_o
);

  localparam int DEPTH = svd_pkg::QDEPTH;
  localparam int AW    = svd_pkg::QAW;

  svd_pkg::svd_item_t mem_r [DEPTH];
  logic [AW-1:0]      wr_r;
  logic [AW-1:0]      rd_r;
  logic [AW:0]        cnt_r;

  assign full_o  = cnt_r == (AW + 1)'(DEPTH);
  assign empty_o = cnt_r == '0;
  assign item_o  = mem_r[rd_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push_i) wr_r <= wr_r + 1'b1;
      if (pop_i) rd_r <= rd_r + 1'b1;
      if (push_i && !pop_i) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_r] <= item_i;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push_i |-> (cnt_r != (AW + 1)'(DEPTH)))
    else $error("request pushed into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop_i |-> (cnt_r != '0))
    else $error("request popped from empty queue");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push_i && !pop_i) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not follow push");

endmodule

/* hdl/svd_back.sv */
// back end: rotation, rotated columns, singular values and left factor
// depends on svd_pkg, svd_isqrt and svd_div; pops requests from svd_queue
module svd_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  svd_pkg::svd_item_t                   item_i,
  input  logic                                 empty_i,
  output logic                                 pop_o,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [svd_pkg::U_W-1:0]       out_u00,
  output logic signed [svd_pkg::U_W-1:0]       out_u01,
  output logic signed [svd_pkg::U_W-1:0]       out_u10,
  output logic signed [svd_pkg::U_W-1:0]       out_u11,
  output logic signed [svd_pkg::U_W-1:0]       out_u20,
  output logic signed [svd_pkg::U_W-1:0]       out_u21,
  output logic [svd_pkg::SIGMA_W-1:0]          out_sigma_first,
  output logic [svd_pkg::SIGMA_W-1:0]          out_sigma_second,
  output logic [svd_pkg::COS_W-1:0]            out_rot_cos,
  output logic signed [svd_pkg::SIN_W-1:0]     out_rot_sin,
  output logic                                 out_rank_deficient
);

  localparam int F     = svd_pkg::FRAC_BITS;
  localparam int NRM_W = svd_pkg::NRM_W;
  localparam int SQ_W  = 2 * NRM_W;
  localparam int CS_SW = svd_pkg::CS_SW;
  localparam int PR_W  = svd_pkg::IN_W + CS_SW;
  localparam int D_W   = PR_W + 1;
  localparam int WM_W  = svd_pkg::WM_W;
  localparam int WQ_W  = 2 * WM_W;
  localparam int SIG_W = svd_pkg::SIG_W;
  localparam int U_W   = svd_pkg::U_W;
  localparam int X_W   = svd_pkg::X_W;

  typedef struct packed {
    svd_pkg::svd_mat_t  a;
    logic [NRM_W-1:0]   pmn;
    logic               sflip;
    logic               ident;
  } r_tag_t;

  typedef struct packed {
    svd_pkg::svd_mat_t  a;
    logic               sflip;
    logic               ident;
    logic               rz;
  } x_tag_t;

  typedef struct packed {
    logic [2:0]             wn;
    logic [2:0][WM_W-1:0]   wm;
    logic [CS_SW-1:0]       cf;
    logic [CS_SW-1:0]       sf;
  } g0_tag_t;

  typedef struct packed {
    logic [2:0]             wn;
    logic [2:0][WM_W-1:0]   wm;
  } g1_tag_t;

  typedef struct packed {
    logic               wn;
    logic [SIG_W-1:0]   sig;
  } u_tag_t;

  typedef struct packed {
    logic [CS_SW-1:0]   cf;
    logic [CS_SW-1:0]   sf;
  } cs_t;

  logic en;

  // global advance: every stage moves unless the result waits
  assign en    = !out_valid || out_ready;
  assign pop_o = !empty_i && en;

  // ---------------- operand staging
  logic                      v0_r, v1_r, v2_r, v3_r;
  svd_pkg::svd_item_t        it0_r;
  r_tag_t                    t1_r, t2_r, t3_r;
  logic [NRM_W-1:0]          qmn1_r;
  logic [SQ_W-1:0]           sqp_r, sqq_r;
  logic [svd_pkg::R_RAD_W-1:0] rad_r;
  r_tag_t                    t1_nxt;
  logic [NRM_W-1:0]          qmn_nxt;

  // normalize p and q below 2^31 with a shared right shift
  always_comb begin
    logic [svd_pkg::M_W-1:0]  v;
    logic [svd_pkg::SH_W-1:0] sh;
    v  = it0_r.pm | it0_r.qm;
    sh = '0;
    for (int j = NRM_W; j < svd_pkg::M_W; j++) begin
      if (v[j]) sh = svd_pkg::SH_W'(j - NRM_W + 1);
    end
    t1_nxt.a     = it0_r.a;
    t1_nxt.pmn   = NRM_W'(it0_r.pm >> sh);
    t1_nxt.sflip = it0_r.sflip;
    t1_nxt.ident = it0_r.ident;
    qmn_nxt      = NRM_W'(it0_r.qm >> sh);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v0_r <= pop_o;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it0_r  <= item_i;
      t1_r   <= t1_nxt;
      qmn1_r <= qmn_nxt;
      sqp_r  <= t1_r.pmn * t1_r.pmn;
      sqq_r  <= qmn1_r * qmn1_r;
      t2_r   <= t1_r;
      rad_r  <= svd_pkg::R_RAD_W'(sqp_r) + svd_pkg::R_RAD_W'(sqq_r);
      t3_r   <= t2_r;
    end
  end

  // ---------------- radius r = sqrt(p^2 + q^2)
  logic                    vr;
  logic [svd_pkg::R_W-1:0] r_root;
  logic [$bits(r_tag_t)-1:0] r_tag_raw;
  r_tag_t                  r_tag;
  x_tag_t                  x_tag_in;

  svd_isqrt #(.RW(svd_pkg::R_RAD_W), .TW($bits(r_tag_t))) u_sqrt_r (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(v3_r), .rad_i(rad_r), .tag_i(t3_r),
    .vld_o(vr), .root_o(r_root), .tag_o(r_tag_raw)
  );

  assign r_tag          = r_tag_t'(r_tag_raw);
  assign x_tag_in.a     = r_tag.a;
  assign x_tag_in.sflip = r_tag.sflip;
  assign x_tag_in.ident = r_tag.ident;
  assign x_tag_in.rz    = r_root == '0;

  // ---------------- x = |p| * 2^F / r
  logic                      vx;
  logic [X_W-1:0]            x_quo;
  logic [$bits(x_tag_t)-1:0] x_tag_raw;
  x_tag_t                    x_tag;
  logic [svd_pkg::X_NUM_W-1:0] x_num;

  assign x_num = svd_pkg::X_NUM_W'(r_tag.pmn) << F;

  svd_div #(.NW(svd_pkg::X_NUM_W), .DW(svd_pkg::R_W), .QW(X_W),
            .TW($bits(x_tag_t))) u_div_x (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(vr), .num_i(x_num), .den_i(r_root), .tag_i(x_tag_in),
    .vld_o(vx), .quo_o(x_quo), .tag_o(x_tag_raw)
  );

  assign x_tag = x_tag_t'(x_tag_raw);

  // ---------------- cosine and sine square roots
  logic [X_W:0]                 xs;
  logic [svd_pkg::CS_RAD_W-1:0] c_rad, s_rad;

  always_comb begin
    xs = x_tag.rz ? '0 : (X_W + 1)'(x_quo);
    if (xs > svd_pkg::ONE) xs = svd_pkg::ONE;
    c_rad = svd_pkg::CS_RAD_W'(svd_pkg::ONE + xs) << (F - 1);
    s_rad = svd_pkg::CS_RAD_W'(svd_pkg::ONE - xs) << (F - 1);
  end

  logic                     vc, vs;
  logic [svd_pkg::CS_W-1:0] c_root, s_root;
  logic [$bits(svd_pkg::svd_mat_t)-1:0] c_tag_raw;
  logic [1:0]               s_tag_raw;
  svd_pkg::svd_mat_t        am;

  svd_isqrt #(.RW(svd_pkg::CS_RAD_W), .TW($bits(svd_pkg::svd_mat_t))) u_sqrt_c (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(vx), .rad_i(c_rad), .tag_i(x_tag.a),
    .vld_o(vc), .root_o(c_root), .tag_o(c_tag_raw)
  );

  svd_isqrt #(.RW(svd_pkg::CS_RAD_W), .TW(2)) u_sqrt_s (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(vx), .rad_i(s_rad), .tag_i({x_tag.sflip, x_tag.ident}),
    .vld_o(vs), .root_o(s_root), .tag_o(s_tag_raw)
  );

  assign am = svd_pkg::svd_mat_t'(c_tag_raw);

  // ---------------- rotated columns W = A * Vt^T
  logic                    v4_r, v5_r, v6_r;
  logic signed [CS_SW-1:0] cf_nxt, sf_nxt;
  logic signed [CS_SW-1:0] cf4_r, sf4_r, cf5_r, sf5_r, cf6_r, sf6_r;
  logic signed [PR_W-1:0]  pac_r [3];
  logic signed [PR_W-1:0]  pbs_r [3];
  logic signed [PR_W-1:0]  pas_r [3];
  logic signed [PR_W-1:0]  pbc_r [3];
  logic [WM_W-1:0]         wm5_r [2][3];
  logic                    wn5_r [2][3];
  logic [WM_W-1:0]         wm_nxt [2][3];
  logic                    wn_nxt [2][3];
  logic [WM_W-1:0]         wm6_r [2][3];
  logic                    wn6_r [2][3];
  logic [WQ_W-1:0]         wq6_r [2][3];

  // pick identity or jacobi rotation, sine sign from p and q
  always_comb begin
    logic signed [CS_SW-1:0] s_ext;
    s_ext  = CS_SW'(s_root);
    cf_nxt = s_tag_raw[0] ? CS_SW'(svd_pkg::ONE) : CS_SW'(c_root);
    sf_nxt = s_tag_raw[0] ? '0 : (s_tag_raw[1] ? -s_ext : s_ext);
  end

  // half-away-from-zero rounding of the rotated entries
  always_comb begin
    logic signed [D_W-1:0] d [2];
    logic [D_W-1:0]        dm;
    logic [D_W-1:0]        rnd;
    for (int i = 0; i < 3; i++) begin
      d[0] = D_W'(pac_r[i]) - D_W'(pbs_r[i]);
      d[1] = D_W'(pas_r[i]) + D_W'(pbc_r[i]);
      for (int k = 0; k < 2; k++) begin
        dm  = d[k][D_W-1] ? D_W'(-d[k]) : D_W'(d[k]);
        rnd = (dm + (D_W'(1) << (F - 1))) >> F;
        wm_nxt[k][i] = rnd[WM_W-1:0];
        wn_nxt[k][i] = d[k][D_W-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else if (en) begin
      v4_r <= vc && vs;
      v5_r <= v4_r;
      v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pac_r[i] <= $signed(am[2*i]) * cf_nxt;
        pbs_r[i] <= $signed(am[2*i+1]) * sf_nxt;
        pas_r[i] <= $signed(am[2*i]) * sf_nxt;
        pbc_r[i] <= $signed(am[2*i+1]) * cf_nxt;
      end
      cf4_r <= cf_nxt;
      sf4_r <= sf_nxt;
      cf5_r <= cf4_r;
      sf5_r <= sf4_r;
      cf6_r <= cf5_r;
      sf6_r <= sf5_r;
      for (int k = 0; k < 2; k++) begin
        for (int i = 0; i < 3; i++) begin
          wm5_r[k][i] <= wm_nxt[k][i];
          wn5_r[k][i] <= wn_nxt[k][i];
          wm6_r[k][i] <= wm5_r[k][i];
          wn6_r[k][i] <= wn5_r[k][i];
          wq6_r[k][i] <= wm5_r[k][i] * wm5_r[k][i];
        end
      end
    end
  end

  // ---------------- singular values
  logic [svd_pkg::SIG_RAD_W-1:0] g_rad [2];
  g0_tag_t                       g0_in;
  g1_tag_t                       g1_in;
  logic [$bits(g0_tag_t)-1:0]    g0_raw;
  logic [$bits(g1_tag_t)-1:0]    g1_raw;
  g0_tag_t                       g0;
  g1_tag_t                       g1;
  logic                          vg0, vg1;
  logic [SIG_W-1:0]              sig [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      g_rad[k] = svd_pkg::SIG_RAD_W'(wq6_r[k][0]) + svd_pkg::SIG_RAD_W'(wq6_r[k][1])
               + svd_pkg::SIG_RAD_W'(wq6_r[k][2]);
    end
    for (int i = 0; i < 3; i++) begin
      g0_in.wn[i] = wn6_r[0][i];
      g0_in.wm[i] = wm6_r[0][i];
      g1_in.wn[i] = wn6_r[1][i];
      g1_in.wm[i] = wm6_r[1][i];
    end
    g0_in.cf = cf6_r;
    g0_in.sf = sf6_r;
  end

  svd_isqrt #(.RW(svd_pkg::SIG_RAD_W), .TW($bits(g0_tag_t))) u_sqrt_g0 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(v6_r), .rad_i(g_rad[0]), .tag_i(g0_in),
    .vld_o(vg0), .root_o(sig[0]), .tag_o(g0_raw)
  );

  svd_isqrt #(.RW(svd_pkg::SIG_RAD_W), .TW($bits(g1_tag_t))) u_sqrt_g1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(v6_r), .rad_i(g_rad[1]), .tag_i(g1_in),
    .vld_o(vg1), .root_o(sig[1]), .tag_o(g1_raw)
  );

  assign g0 = g0_tag_t'(g0_raw);
  assign g1 = g1_tag_t'(g1_raw);

  // ---------------- left factor U = W * 2^F / sigma
  cs_t                 cs_dly_r [X_W];
  logic [5:0]          vu;
  logic [X_W-1:0]      u_quo [2][3];
  u_tag_t              u_tag [2][3];
  logic signed [U_W-1:0] u_val [2][3];
  logic                sigz [2];

  for (genvar k = 0; k < 2; k++) begin : g_col
    for (genvar i = 0; i < 3; i++) begin : g_row
      logic [WM_W-1:0]             wmag;
      logic                        wneg;
      logic [svd_pkg::U_NUM_W-1:0] num;
      logic [$bits(u_tag_t)-1:0]   traw;
      u_tag_t                      tin;

      assign wmag    = (k == 0) ? g0.wm[i] : g1.wm[i];
      assign wneg    = (k == 0) ? g0.wn[i] : g1.wn[i];
      assign num     = (svd_pkg::U_NUM_W'(wmag) << F)
                     + svd_pkg::U_NUM_W'(sig[k] >> 1);
      assign tin.wn  = wneg;
      assign tin.sig = sig[k];

      svd_div #(.NW(svd_pkg::U_NUM_W), .DW(SIG_W), .QW(X_W),
                .TW($bits(u_tag_t))) u_div_u (
        .clk(clk), .rst_n(rst_n), .en(en),
        .vld_i(vg0 && vg1), .num_i(num), .den_i(sig[k]), .tag_i(tin),
        .vld_o(vu[3*k+i]), .quo_o(u_quo[k][i]), .tag_o(traw)
      );

      assign u_tag[k][i] = u_tag_t'(traw);
    end
  end

  // rotation follows the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      cs_dly_r[0].cf <= g0.cf;
      cs_dly_r[0].sf <= g0.sf;
      for (int j = 1; j < X_W; j++) cs_dly_r[j] <= cs_dly_r[j-1];
    end
  end

  // sign, zero column for a zero singular value
  always_comb begin
    logic [U_W-1:0] qe;
    for (int k = 0; k < 2; k++) begin
      sigz[k] = u_tag[k][0].sig == '0;
      for (int i = 0; i < 3; i++) begin
        qe = U_W'(u_quo[k][i]);
        if (u_tag[k][i].sig == '0) begin
          u_val[k][i] = '0;
        end else if (u_tag[k][i].wn) begin
          u_val[k][i] = -$signed(qe);
        end else begin
          u_val[k][i] = $signed(qe);
        end
      end
    end
  end

  // ---------------- result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= &vu;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_u00            <= u_val[0][0];
      out_u01            <= u_val[1][0];
      out_u10            <= u_val[0][1];
      out_u11            <= u_val[1][1];
      out_u20            <= u_val[0][2];
      out_u21            <= u_val[1][2];
      out_sigma_first    <= u_tag[0][0].sig[svd_pkg::SIGMA_W-1:0];
      out_sigma_second   <= u_tag[1][0].sig[svd_pkg::SIGMA_W-1:0];
      out_rot_cos        <= cs_dly_r[X_W-1].cf[svd_pkg::COS_W-1:0];
      out_rot_sin        <= cs_dly_r[X_W-1].sf[svd_pkg::SIN_W-1:0];
      out_rank_deficient <= sigz[0] || sigz[1];
    end
  end

endmodule

/* hdl/svd_3x2_closed_form_top.sv */
// throughput: one matrix per cycle; the square root and divider pipelines
// resolve one bit per stage, and the whole back end holds while a result waits
// a four-entry queue lets the front end keep accepting during such holds
// reset: synchronous active-low rst_n empties all pipelines and the queue,
// and sets eps_threshold to 1
module svd_3x2_closed_form_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [svd_pkg::PADDR_W-1:0]          paddr,
  input  logic [svd_pkg::PDATA_W-1:0]          pwdata,
  output logic [svd_pkg::PDATA_W-1:0]          prdata,
  output logic                                 pready,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [svd_pkg::IN_W-1:0]      in_a00,
  input  logic signed [svd_pkg::IN_W-1:0]      in_a01,
  input  logic signed [svd_pkg::IN_W-1:0]      in_a10,
  input  logic signed [svd_pkg::IN_W-1:0]      in_a11,
  input  logic signed [svd_pkg::IN_W-1:0]      in_a20,
  input  logic signed [svd_pkg::IN_W-1:0]      in_a21,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [svd_pkg::U_W-1:0]       out_u00,
  output logic signed [svd_pkg::U_W-1:0]       out_u01,
  output logic signed [svd_pkg::U_W-1:0]       out_u10,
  output logic signed [svd_pkg::U_W-1:0]       out_u11,
  output logic signed [svd_pkg::U_W-1:0]       out_u20,
  output logic signed [svd_pkg::U_W-1:0]       out_u21,
  output logic [svd_pkg::SIGMA_W-1:0]          out_sigma_first,
  output logic [svd_pkg::SIGMA_W-1:0]          out_sigma_second,
  output logic [svd_pkg::COS_W-1:0]            out_rot_cos,
  output logic signed [svd_pkg::SIN_W-1:0]     out_rot_sin,
  output logic                                 out_rank_deficient
);

  logic [svd_pkg::EPS_W-1:0] eps_r;
  logic                      cfg_wr;
  logic                      q_full, q_empty, q_push, q_pop;
  svd_pkg::svd_item_t        q_in, q_out;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[2] == svd_pkg::REG_EPS_THRESHOLD);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= svd_pkg::EPS_RESET;
    end else if (cfg_wr) begin
      eps_r <= pwdata[svd_pkg::EPS_W-1:0];
    end
  end

  assign prdata = (paddr[2] == svd_pkg::REG_EPS_THRESHOLD)
                ? svd_pkg::PDATA_W'(eps_r) : '0;

  svd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_a00(in_a00), .in_a01(in_a01), .in_a10(in_a10),
    .in_a11(in_a11), .in_a20(in_a20), .in_a21(in_a21),
    .eps_i(eps_r), .full_i(q_full), .push_o(q_push), .item_o(q_in)
  );

  svd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .push_i(q_push), .item_i(q_in), .full_o(q_full),
    .pop_i(q_pop), .empty_o(q_empty), .item_o(q_out)
  );

  svd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .item_i(q_out), .empty_i(q_empty), .pop_o(q_pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_u00(out_u00), .out_u01(out_u01), .out_u10(out_u10),
    .out_u11(out_u11), .out_u20(out_u20), .out_u21(out_u21),
    .out_sigma_first(out_sigma_first), .out_sigma_second(out_sigma_second),
    .out_rot_cos(out_rot_cos), .out_rot_sin(out_rot_sin),
    .out_rank_deficient(out_rank_deficient)
  );

endmodule
